/* rtl/arffp_pkg.sv */
package arffp_pkg;

	localparam int COORD_BITS     = 12;
	localparam int DIM_BITS       = COORD_BITS + 1;
	localparam int MAX_FREE_RECTS = 64;
	localparam int CNT_BITS       = $clog2(MAX_FREE_RECTS + 1);

	localparam logic [DIM_BITS-1:0] DIM_TOP   = DIM_BITS'(1 << COORD_BITS);
	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(1024);

	// status codes
	localparam logic [1:0] ST_PLACED  = 2'd0;
	localparam logic [1:0] ST_NO_FIT  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	// request types
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// register indexes
	localparam logic REG_ATLAS_WIDTH  = 1'b0;
	localparam logic REG_ATLAS_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [DIM_BITS-1:0]   w;
		logic [DIM_BITS-1:0]   h;
	} rect_t;

	localparam rect_t RESET_RECT = '{x: '0, y: '0, w: DIM_RESET, h: DIM_RESET};

	typedef struct packed {
		logic                  req_type;
		logic [COORD_BITS-1:0] req_width;
		logic [COORD_BITS-1:0] req_height;
	} in_word_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [COORD_BITS-1:0] place_x;
		logic [COORD_BITS-1:0] place_y;
		logic [DIM_BITS-1:0]   granted_width;
		logic [DIM_BITS-1:0]   granted_height;
	} out_word_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_SPLIT,
		OP_REMOVE
	} cell_op_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_op_t            op;
		rect_t               a;
		rect_t               b;
		rect_t               full;
		logic [DIM_BITS-1:0] pw;
		logic [DIM_BITS-1:0] ph;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIT,
		S_SEL,
		S_PICK,
		S_APPLY
	} state_t;

endpackage

/* rtl/atlas_rect_first_fit_packer_unit.sv */
// channel | valid    | stall     | word
// input   | in_valid | in_stall  | in_word  (req_type, req_width, req_height)
// output  | out_valid| out_stall | out_word (status, place_x/y, granted size)
// config  | APB write at psel & penable & pwrite, pready tied high
// An item goes through accept, fit compare in every cell, first-fit token
// ripple down the cell row, chosen rectangle pick, list update and result.
// The result register lets the next item be accepted while a result waits;
// the update waits in the pick step while that register is still stalled.
// After reset the list holds one 1024 x 1024 rectangle; no clearing pass.
module atlas_rect_first_fit_packer_unit
	import arffp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cell_cmd_t cmd;
	rect_t     rect  [MAX_FREE_RECTS];
	logic      valid [MAX_FREE_RECTS];
	logic      sel   [MAX_FREE_RECTS];
	logic      taken [MAX_FREE_RECTS+1];
	rect_t     pick  [MAX_FREE_RECTS+1];

	assign taken[0] = 1'b0;
	assign pick[0]  = '0;

	arffp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.hit(taken[MAX_FREE_RECTS]), .chosen(pick[MAX_FREE_RECTS]), .cmd(cmd)
	);

	// row of free-list cells, entry 0 at the head
	for (genvar k = 0; k < MAX_FREE_RECTS; k++) begin : g_cell
		rect_t p_rect, n_rect;
		logic  p_valid, p_sel, n_valid;
		if (k == 0) begin : g_head
			assign p_rect  = '0;
			assign p_valid = 1'b0;
			assign p_sel   = 1'b0;
		end else begin : g_mid
			assign p_rect  = rect[k-1];
			assign p_valid = valid[k-1];
			assign p_sel   = sel[k-1];
		end
		if (k == MAX_FREE_RECTS - 1) begin : g_tail
			assign n_rect  = '0;
			assign n_valid = 1'b0;
		end else begin : g_body
			assign n_rect  = rect[k+1];
			assign n_valid = valid[k+1];
		end
		arffp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .head(k == 0), .cmd(cmd),
			.prev_rect(p_rect), .prev_valid(p_valid), .prev_sel(p_sel),
			.next_rect(n_rect), .next_valid(n_valid),
			.taken_in(taken[k]), .pick_in(pick[k]),
			.rect(rect[k]), .valid(valid[k]), .sel(sel[k]),
			.taken_out(taken[k+1]), .pick_out(pick[k+1])
		);
	end

endmodule

/* rtl/arffp_cell.sv */
module arffp_cell
	import arffp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head,
	input  cell_cmd_t cmd,
	input  rect_t     prev_rect,
	input  logic      prev_valid,
	input  logic      prev_sel,
	input  rect_t     next_rect,
	input  logic      next_valid,
	input  logic      taken_in,
	input  rect_t     pick_in,
	output rect_t     rect,
	output logic      valid,
	output logic      sel,
	output logic      taken_out,
	output rect_t     pick_out
);

	rect_t rect_q;
	logic  valid_q;
	logic  fit_q;
	logic  sel_q;
	logic  after_q;

	// first-fit token ripples from the head of the row
	assign taken_out = taken_in | fit_q;
	assign pick_out  = sel_q ? (pick_in | rect_q) : pick_in;
	assign rect      = rect_q;
	assign valid     = valid_q;
	assign sel       = sel_q;

	// fit compare and selection flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q   <= 1'b0;
			sel_q   <= 1'b0;
			after_q <= 1'b0;
		end else begin
			fit_q   <= valid_q && (cmd.pw <= rect_q.w) && (cmd.ph <= rect_q.h);
			sel_q   <= fit_q & ~taken_in;
			after_q <= taken_in;
		end
	end

	// list update: clear keeps only the head, shift toward the tail on split, toward the head on remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_q  <= RESET_RECT;
			valid_q <= head;
		end else begin
			unique case (cmd.op)
				OP_CLEAR: begin
					if (head) rect_q <= cmd.full;
					valid_q <= head;
				end
				OP_SPLIT: begin
					if (sel_q) begin
						rect_q  <= cmd.a;
						valid_q <= 1'b1;
					end else if (after_q && prev_sel) begin
						rect_q  <= cmd.b;
						valid_q <= 1'b1;
					end else if (after_q) begin
						rect_q  <= prev_rect;
						valid_q <= prev_valid;
					end
				end
				OP_REMOVE: begin
					if (sel_q || after_q) begin
						rect_q  <= next_rect;
						valid_q <= next_valid;
					end
				end
				OP_HOLD: ;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/arffp_ctrl.sv */
module arffp_ctrl
	import arffp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        hit,
	input  rect_t       chosen,
	output cell_cmd_t   cmd
);

	state_t              state_q, state_d;
	in_word_t            req_q;
	logic [DIM_BITS-1:0] atlas_w_q, atlas_h_q;
	logic [CNT_BITS-1:0] count_q;
	logic                hit_q;
	rect_t               c_q;
	logic                out_valid_q;
	out_word_t           out_q;

	logic                in_acc, cfg_wr, out_free;
	logic [DIM_BITS-1:0] pw, ph, rw, rh;
	logic                need_split;
	rect_t               a, b, full;
	cell_op_t            apply_op;
	out_word_t           res;

	assign in_acc   = in_valid && !in_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !out_valid_q || !out_stall;
	assign pready   = 1'b1;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= DIM_RESET;
			atlas_h_q <= DIM_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ATLAS_WIDTH:  atlas_w_q <= pwdata[DIM_BITS-1:0];
				REG_ATLAS_HEIGHT: atlas_h_q <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ATLAS_WIDTH:  prdata = 32'(atlas_w_q);
			REG_ATLAS_HEIGHT: prdata = 32'(atlas_h_q);
			default:          prdata = '0;
		endcase
	end

	// padded size, guillotine split of the chosen rectangle and clamped full-atlas rectangle
	assign pw = DIM_BITS'(req_q.req_width) + DIM_BITS'(1);
	assign ph = DIM_BITS'(req_q.req_height) + DIM_BITS'(1);
	assign rw = c_q.w - pw;
	assign rh = c_q.h - ph;
	assign need_split = (rw >= DIM_BITS'(2)) || (rh >= DIM_BITS'(2));

	always_comb begin
		if (rh <= rw) begin
			a = '{x: c_q.x, y: c_q.y + ph[COORD_BITS-1:0], w: pw, h: rh};
			b = '{x: c_q.x + pw[COORD_BITS-1:0], y: c_q.y, w: rw, h: c_q.h};
		end else begin
			a = '{x: c_q.x + pw[COORD_BITS-1:0], y: c_q.y, w: rw, h: ph};
			b = '{x: c_q.x, y: c_q.y + ph[COORD_BITS-1:0], w: c_q.w, h: rh};
		end
		full.x = '0;
		full.y = '0;
		full.w = (atlas_w_q > DIM_TOP) ? DIM_TOP : atlas_w_q;
		full.h = (atlas_h_q > DIM_TOP) ? DIM_TOP : atlas_h_q;
	end

	// decision and result word
	always_comb begin
		res      = '0;
		apply_op = OP_HOLD;
		priority if (req_q.req_type == REQ_CLEAR) begin
			res.status = ST_CLEARED;
			apply_op   = OP_CLEAR;
		end else if (!hit_q) begin
			res.status = ST_NO_FIT;
		end else if (need_split && (count_q >= CNT_BITS'(MAX_FREE_RECTS))) begin
			res.status = ST_FULL;
		end else begin
			res.status         = ST_PLACED;
			res.place_x        = c_q.x;
			res.place_y        = c_q.y;
			res.granted_width  = pw;
			res.granted_height = ph;
			apply_op           = need_split ? OP_SPLIT : OP_REMOVE;
		end
	end

	// cell broadcast
	always_comb begin
		cmd.op   = (state_q == S_APPLY) ? apply_op : OP_HOLD;
		cmd.a    = a;
		cmd.b    = b;
		cmd.full = full;
		cmd.pw   = pw;
		cmd.ph   = ph;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_acc) state_d = S_FIT;
			S_FIT:   state_d = S_SEL;
			S_SEL:   state_d = S_PICK;
			S_PICK:  if (out_free) state_d = S_APPLY;
			S_APPLY: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (in_acc) req_q <= in_word;
		hit_q <= hit;
		c_q   <= chosen;
	end

	// free count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_BITS'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_APPLY) begin
				out_valid_q <= 1'b1;
				unique case (apply_op)
					OP_CLEAR:  count_q <= CNT_BITS'(1);
					OP_SPLIT:  count_q <= count_q + CNT_BITS'(1);
					OP_REMOVE: count_q <= count_q - CNT_BITS'(1);
					OP_HOLD:   ;
					default:   ;
				endcase
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) out_q <= res;
	end

endmodule

/* rtl/arffp_checker.sv */
module arffp_checker
	import arffp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word,
	input logic      pready
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed under stall");

	// only placed results carry a position and size
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status != ST_PLACED |->
			out_word.place_x == '0 && out_word.place_y == '0 &&
			out_word.granted_width == '0 && out_word.granted_height == '0)
		else $error("non-placed result with fields set");

	// padded size is never zero
	a_padded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == ST_PLACED |->
			out_word.granted_width != '0 && out_word.granted_height != '0)
		else $error("placed result with zero size");

	// one request in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while busy");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind atlas_rect_first_fit_packer_unit arffp_checker u_arffp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
	.pready(pready)
);

/* test/tb_top.sv */
module tb_top;
	import arffp_pkg::*;

	localparam int LIST_DEPTH = MAX_FREE_RECTS;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_word;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	atlas_rect_first_fit_packer_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor copy of the free list and registers
	rect_t             free_list [LIST_DEPTH];
	int unsigned       free_cnt;
	logic [12:0]       atlas_w_reg;
	logic [12:0]       atlas_h_reg;

	in_word_t          pending_words [$];
	out_word_t         expected_grants [$];
	int                mismatch_cnt;
	int                sent_cnt;
	int                got_cnt;

	// idling controls
	bit                quiet_in;
	bit                quiet_out;
	int                hold_out_cycles;
	bit                send_pause;
	bit                in_taken;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [12:0] clamp_dim(logic [12:0] v);
		return (v > 13'd4096) ? 13'd4096 : v;
	endfunction

	function automatic void reset_list();
		free_list[0].x = '0;
		free_list[0].y = '0;
		free_list[0].w = clamp_dim(atlas_w_reg);
		free_list[0].h = clamp_dim(atlas_h_reg);
		free_cnt = 1;
	endfunction

	// compute the grant for one request and update the free list
	function automatic out_word_t pack_request(in_word_t rq);
		out_word_t r;
		logic [12:0] pw, ph, rw, rh;
		rect_t c, a, b;
		int idx;
		r = '0;
		idx = -1;
		pw = {1'b0, rq.req_width} + 13'd1;
		ph = {1'b0, rq.req_height} + 13'd1;
		if (rq.req_type == REQ_CLEAR) begin
			reset_list();
			r.status = ST_CLEARED;
			return r;
		end
		for (int i = 0; i < free_cnt; i++) begin
			if (idx < 0 && pw <= free_list[i].w && ph <= free_list[i].h)
				idx = i;
		end
		if (idx < 0) begin
			r.status = ST_NO_FIT;
			return r;
		end
		c = free_list[idx];
		rw = c.w - pw;
		rh = c.h - ph;
		if (rw >= 2 || rh >= 2) begin
			if (free_cnt + 1 > LIST_DEPTH) begin
				r.status = ST_FULL;
				return r;
			end
			if (rh <= rw) begin
				a.x = c.x; a.y = c.y + ph[11:0]; a.w = pw; a.h = rh;
				b.x = c.x + pw[11:0]; b.y = c.y; b.w = rw; b.h = c.h;
			end else begin
				a.x = c.x + pw[11:0]; a.y = c.y; a.w = rw; a.h = ph;
				b.x = c.x; b.y = c.y + ph[11:0]; b.w = c.w; b.h = rh;
			end
			for (int k = free_cnt; k > idx + 1; k--)
				free_list[k] = free_list[k-1];
			free_list[idx] = a;
			free_list[idx+1] = b;
			free_cnt++;
		end else begin
			for (int k = idx; k + 1 < free_cnt; k++)
				free_list[k] = free_list[k+1];
			free_cnt--;
		end
		r.status = ST_PLACED;
		r.place_x = c.x;
		r.place_y = c.y;
		r.granted_width = pw;
		r.granted_height = ph;
		return r;
	endfunction

	// driver: offer words from the pending queue
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// hold the stalled word
			end else begin
				if (in_taken)
					void'(pending_words.pop_front());
				in_taken = 1'b0;
				if (pending_words.size() > 0 && !send_pause &&
						(quiet_in || $urandom_range(99) >= 17)) begin
					in_valid <= 1'b1;
					in_word  <= pending_words[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (hold_out_cycles > 0) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_out && ($urandom_range(99) < 17);
			end
		end
	end

	// receiver hold-off counter
	always @(posedge clk) begin
		if (hold_out_cycles > 0)
			hold_out_cycles <= hold_out_cycles - 1;
	end

	// monitor: predict on accept, check on result
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_grants.push_back(pack_request(in_word));
				sent_cnt++;
				in_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				got_cnt++;
				if (expected_grants.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected word %h", out_word);
				end else begin
					out_word_t e;
					e = expected_grants.pop_front();
					if (e.status != out_word.status || e.place_x != out_word.place_x ||
							e.place_y != out_word.place_y ||
							e.granted_width != out_word.granted_width ||
							e.granted_height != out_word.granted_height) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: exp st=%0d x=%0d y=%0d w=%0d h=%0d",
								e.status, e.place_x, e.place_y, e.granted_width,
								e.granted_height,
								" got st=%0d x=%0d y=%0d w=%0d h=%0d",
								out_word.status, out_word.place_x,
								out_word.place_y, out_word.granted_width,
								out_word.granted_height);
					end
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || expected_grants.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// APB write, setup then access, driven on falling edges
	task automatic reg_write(logic idx, logic [12:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= {19'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_ATLAS_WIDTH) atlas_w_reg = val;
		else atlas_h_reg = val;
	endtask

	function automatic in_word_t make_word(logic t, logic [11:0] w, logic [11:0] h);
		in_word_t q;
		q.req_type = t; q.req_width = w; q.req_height = h;
		return q;
	endfunction

	// one random phase: a clear followed by allocations of varied sizes, with occasional clears
	task automatic queue_phase(int n_items, int size_cap);
		pending_words.push_back(make_word(REQ_CLEAR, 12'($urandom), 12'($urandom)));
		for (int i = 0; i < n_items; i++) begin
			int pick;
			pick = $urandom_range(99);
			if (pick < 3)
				pending_words.push_back(make_word(REQ_CLEAR, 12'($urandom),
					12'($urandom)));
			else if (pick < 8)
				pending_words.push_back(make_word(REQ_ALLOC, 12'($urandom),
					12'($urandom)));
			else
				pending_words.push_back(make_word(REQ_ALLOC,
					12'($urandom_range(size_cap)), 12'($urandom_range(size_cap))));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; in_word = '0; out_stall = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		quiet_in = 0; quiet_out = 0; hold_out_cycles = 0; send_pause = 0;
		in_taken = 0;
		mismatch_cnt = 0; sent_cnt = 0; got_cnt = 0;
		atlas_w_reg = 13'd1024; atlas_h_reg = 13'd1024;
		free_cnt = 0;
		for (int i = 0; i < LIST_DEPTH; i++) free_list[i] = '0;
		reset_list();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset list, extremes, exact fit removal, no fit
		pending_words.push_back(make_word(REQ_ALLOC, 12'd0, 12'd0));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd4095, 12'd4095));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd1022, 12'd0));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd100, 12'd500));
		pending_words.push_back(make_word(REQ_CLEAR, 12'hfff, 12'hfff));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd1023, 12'd1023));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd0, 12'd0));
		pending_words.push_back(make_word(REQ_CLEAR, 12'd0, 12'd0));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd1022, 12'd1022));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd0, 12'd0));
		wait_drained();

		// saturated atlas, full table by tiny allocations
		reg_write(REG_ATLAS_WIDTH, 13'h1fff);
		reg_write(REG_ATLAS_HEIGHT, 13'd4096);
		pending_words.push_back(make_word(REQ_CLEAR, 12'd0, 12'd0));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd4095, 12'd0));
		pending_words.push_back(make_word(REQ_CLEAR, 12'd0, 12'd0));
		for (int i = 0; i < 70; i++)
			pending_words.push_back(make_word(REQ_ALLOC, 12'd0, 12'd0));
		wait_drained();

		// zero-size atlas: nothing fits
		reg_write(REG_ATLAS_WIDTH, 13'd0);
		reg_write(REG_ATLAS_HEIGHT, 13'd1);
		pending_words.push_back(make_word(REQ_CLEAR, 12'd0, 12'd0));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd0, 12'd0));
		wait_drained();

		// tiny atlas: exact fits and removal to empty list
		reg_write(REG_ATLAS_WIDTH, 13'd2);
		reg_write(REG_ATLAS_HEIGHT, 13'd2);
		pending_words.push_back(make_word(REQ_CLEAR, 12'd0, 12'd0));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd1, 12'd1));
		pending_words.push_back(make_word(REQ_ALLOC, 12'd0, 12'd0));
		wait_drained();

		// random phases; one with a long receiver hold-off
		reg_write(REG_ATLAS_WIDTH, 13'd256);
		reg_write(REG_ATLAS_HEIGHT, 13'd128);
		queue_phase(150, 40);
		@(negedge clk);
		hold_out_cycles = 60;
		wait_drained();

		// sender pauses mid-phase until everything has returned
		reg_write(REG_ATLAS_WIDTH, 13'd1);
		reg_write(REG_ATLAS_HEIGHT, 13'd4096);
		queue_phase(60, 3);
		repeat (100) @(negedge clk);
		send_pause = 1;
		wait (expected_grants.size() == 0);
		repeat (5) @(negedge clk);
		send_pause = 0;
		wait_drained();

		reg_write(REG_ATLAS_WIDTH, 13'd4096);
		reg_write(REG_ATLAS_HEIGHT, 13'd4096);
		quiet_in = 1; quiet_out = 1;
		queue_phase(150, 600);
		wait_drained();
		quiet_in = 0; quiet_out = 0;

		reg_write(REG_ATLAS_WIDTH, 13'd60);
		reg_write(REG_ATLAS_HEIGHT, 13'd3000);
		queue_phase(150, 20);
		wait_drained();

		if (mismatch_cnt == 0 && expected_grants.size() == 0)
			$display("atlas_rect_first_fit_packer_unit verification clean");
		else
			$display("atlas_rect_first_fit_packer_unit verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("atlas_rect_first_fit_packer_unit verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/arffp_pkg.sv
rtl/arffp_cell.sv
rtl/arffp_ctrl.sv
rtl/atlas_rect_first_fit_packer_unit.sv
rtl/arffp_checker.sv
test/tb_top.sv
